[hdl/pscl_pkg.sv]
package pscl_pkg;

    // Build-time defaults
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int COUNT_BITS_DEF    = 16;

    // Fixed field widths
    localparam int TOTAL_W = 22;
    localparam int APB_AW  = 3;

    // Sources that bypass the count and gap checks
    localparam logic [31:0] LOOPBACK_A = 32'h7F00_0001;
    localparam logic [31:0] LOOPBACK_B = 32'h7F00_0007;

    // Register map, indexed by paddr[2]
    localparam logic REG_MAX_CONN = 1'b0;
    localparam logic REG_MIN_GAP  = 1'b1;

    // Register reset values
    localparam logic [15:0] MAX_CONN_RST = 16'd16;
    localparam logic [9:0]  MIN_GAP_RST  = 10'd100;

    typedef enum logic [2:0] {
        ST_ADMIT    = 3'd0,
        ST_OVER     = 3'd1,
        ST_FREQ     = 3'd2,
        ST_FULL     = 3'd3,
        ST_REL      = 3'd4,
        ST_FREED    = 3'd5,
        ST_NOTFOUND = 3'd6
    } t_status;

    typedef struct packed {
        logic        func;
        logic [31:0] source_ip;
        logic [31:0] now_ms;
    } t_item;

    typedef struct packed {
        logic                accepted;
        logic [2:0]          status;
        logic [15:0]         source_count;
        logic [TOTAL_W-1:0]  total_count;
    } t_result;

    // Controller state
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_EXEC
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic scan;
        logic exec;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clear_done;
        logic scan_done;
    } t_dp_stat;

endpackage

[hdl/pscl_ctrl.sv]
module pscl_ctrl
    import pscl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    t_state r_state;
    t_state n_state;

    // State register; reset enters the table clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[hdl/pscl_dp.sv]
module pscl_dp
    import pscl_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  t_item       i_item,
    input  logic [15:0] i_max_conn,
    input  logic [9:0]  i_min_gap,
    output t_result     o_result,
    output logic        o_done
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

    typedef struct packed {
        logic                  valid;
        logic [31:0]           ip;
        logic [COUNT_BITS-1:0] cnt;
        logic [31:0]           last;
    } t_entry;

    // Source table
    t_entry r_mem [TABLE_ENTRIES];
    t_entry r_rd_data;

    // Control registers
    logic [AW-1:0]      r_rd_addr;
    logic               r_issue_done;
    logic               r_rd_pend;
    logic               r_hit;
    logic               r_free_found;
    logic [TOTAL_W-1:0] r_total;
    logic               r_done;

    // Payload registers
    logic                  r_func;
    logic [31:0]           r_ip;
    logic [31:0]           r_now;
    logic [AW-1:0]         r_chk_addr;
    logic [AW-1:0]         r_hit_addr;
    logic [COUNT_BITS-1:0] r_hit_cnt;
    logic [31:0]           r_hit_last;
    logic [AW-1:0]         r_free_addr;
    t_result               r_result;

    // Decision wires
    logic                  w_match;
    logic                  w_local;
    logic                  w_total_full;
    logic [31:0]           w_elapsed;
    t_status               w_status;
    logic                  w_wr;
    logic [AW-1:0]         w_wr_addr;
    t_entry                w_wr_data;
    logic [TOTAL_W-1:0]    n_total;
    logic [COUNT_BITS-1:0] w_src;
    logic [COUNT_BITS-1:0] w_cnt_dec;
    logic [31:0]           w_src32;
    logic                  w_mem_we;
    logic [AW-1:0]         w_mem_addr;
    t_entry                w_mem_wd;

    // Compare of the entry under evaluation
    assign w_match = r_rd_data.valid && (r_rd_data.ip == r_ip);

    assign o_stat.clear_done = i_cmd.clear && (r_rd_addr == LAST);
    assign o_stat.scan_done  = i_cmd.scan && r_rd_pend && (w_match || (r_chk_addr == LAST));

    // Table port: clearing pass or write-back
    assign w_mem_we   = i_cmd.clear || (i_cmd.exec && w_wr);
    assign w_mem_addr = i_cmd.clear ? r_rd_addr : w_wr_addr;
    assign w_mem_wd   = i_cmd.clear ? t_entry'('0) : w_wr_data;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= w_mem_wd;
        end
        r_rd_data <= r_mem[r_rd_addr];
    end

    // Scan / clear counter and control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_addr    <= '0;
            r_issue_done <= 1'b0;
            r_rd_pend    <= 1'b0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_total      <= '0;
            r_done       <= 1'b0;
        end else begin
            r_done <= i_cmd.exec;
            if (i_cmd.clear) begin
                r_rd_addr <= (r_rd_addr == LAST) ? '0 : r_rd_addr + AW'(1);
            end
            if (i_cmd.load) begin
                r_rd_addr    <= '0;
                r_issue_done <= 1'b0;
                r_rd_pend    <= 1'b0;
                r_hit        <= 1'b0;
                r_free_found <= 1'b0;
            end
            if (i_cmd.scan) begin
                r_rd_pend <= !r_issue_done;
                if (!r_issue_done) begin
                    r_issue_done <= (r_rd_addr == LAST);
                    if (r_rd_addr != LAST) begin
                        r_rd_addr <= r_rd_addr + AW'(1);
                    end
                end
                if (r_rd_pend) begin
                    if (w_match) begin
                        r_hit <= 1'b1;
                    end
                    if (!r_rd_data.valid) begin
                        r_free_found <= 1'b1;
                    end
                end
            end
            if (i_cmd.exec) begin
                r_total <= n_total;
            end
        end
    end

    // Payload captures
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_item.func;
            r_ip   <= i_item.source_ip;
            r_now  <= i_item.now_ms;
        end
        if (i_cmd.scan) begin
            r_chk_addr <= r_rd_addr;
            if (r_rd_pend && w_match && !r_hit) begin
                r_hit_addr <= r_chk_addr;
                r_hit_cnt  <= r_rd_data.cnt;
                r_hit_last <= r_rd_data.last;
            end
            if (r_rd_pend && !r_rd_data.valid && !r_free_found) begin
                r_free_addr <= r_chk_addr;
            end
        end
        if (i_cmd.exec) begin
            r_result.accepted     <= (w_status == ST_ADMIT) || (w_status == ST_REL)
                                     || (w_status == ST_FREED);
            r_result.status       <= w_status;
            r_result.source_count <= w_src32[15:0];
            r_result.total_count  <= n_total;
        end
    end

    // Admission / release decision on the captured entry
    assign w_local      = (r_ip == LOOPBACK_A) || (r_ip == LOOPBACK_B);
    assign w_total_full = &r_total;
    assign w_elapsed    = r_now - r_hit_last;
    assign w_cnt_dec    = (r_hit_cnt != '0) ? r_hit_cnt - COUNT_BITS'(1) : r_hit_cnt;
    assign w_src32      = 32'(w_src);

    always_comb begin
        w_status  = ST_NOTFOUND;
        w_wr      = 1'b0;
        w_wr_addr = r_hit ? r_hit_addr : r_free_addr;
        w_wr_data = '{valid: 1'b1, ip: r_ip, cnt: r_hit_cnt, last: r_now};
        n_total   = r_total;
        w_src     = '0;
        if (!r_func) begin
            if (r_hit) begin
                // known source: attempt time is always recorded
                w_wr = 1'b1;
                if (!w_local && (32'(r_hit_cnt) > 32'(i_max_conn))) begin
                    w_status = ST_OVER;
                end else if (!w_local && (w_elapsed < 32'(i_min_gap))) begin
                    w_status = ST_FREQ;
                end else if ((&r_hit_cnt) || w_total_full) begin
                    w_status = ST_OVER;
                end else begin
                    w_status      = ST_ADMIT;
                    w_wr_data.cnt = r_hit_cnt + COUNT_BITS'(1);
                    n_total       = r_total + TOTAL_W'(1);
                end
                w_src = w_wr_data.cnt;
            end else if (!r_free_found) begin
                w_status = ST_FULL;
            end else if (w_total_full) begin
                w_status = ST_OVER;
            end else begin
                // new source in the lowest free slot
                w_status      = ST_ADMIT;
                w_wr          = 1'b1;
                w_wr_data.cnt = COUNT_BITS'(1);
                n_total       = r_total + TOTAL_W'(1);
                w_src         = COUNT_BITS'(1);
            end
        end else if (r_hit) begin
            w_wr           = 1'b1;
            w_wr_data.cnt  = w_cnt_dec;
            w_wr_data.last = r_hit_last;
            if (r_total != '0) begin
                n_total = r_total - TOTAL_W'(1);
            end
            if (w_cnt_dec == '0) begin
                // last connection gone: free the slot
                w_status        = ST_FREED;
                w_wr_data.valid = 1'b0;
            end else begin
                w_status = ST_REL;
                w_src    = w_cnt_dec;
            end
        end
    end

    assign o_result = r_result;
    assign o_done   = r_done;

endmodule

[hdl/per_source_connection_limiter.sv]
// Channel   Ports                                   Beat taken when
// ------    -----                                   ---------------
// command   start, busy, i_item                     start && !busy
// result    o_done, o_result                        o_done (one cycle, no stall)
// config    psel, penable, pwrite, paddr, pwdata,   psel && penable && pwrite
//           prdata, pready
//
// Each command runs from accept to result strobe as a sequential scan of the
// source table, one entry per cycle through its single registered read port,
// then a decide and write-back step. The scan ends early on the first
// matching entry.
// After reset the table is swept clear, one entry at a time, with busy high.
// The result strobe comes in the cycle busy falls; the receiver cannot stall.
module per_source_connection_limiter
    import pscl_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_item             i_item,
    output logic              o_done,
    output t_result           o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [15:0] r_max_conn;
    logic [9:0]  r_min_gap;
    t_dp_cmd     w_cmd;
    t_dp_stat    w_stat;
    logic        w_cfg_wr;

    // Configuration registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_conn <= MAX_CONN_RST;
            r_min_gap  <= MIN_GAP_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_MAX_CONN: r_max_conn <= pwdata[15:0];
                REG_MIN_GAP:  r_min_gap  <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MAX_CONN: prdata = {16'b0, r_max_conn};
            REG_MIN_GAP:  prdata = {22'b0, r_min_gap};
            default:      prdata = '0;
        endcase
    end

    pscl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    pscl_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNT_BITS    (COUNT_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_item     (i_item),
        .i_max_conn (r_max_conn),
        .i_min_gap  (r_min_gap),
        .o_result   (o_result),
        .o_done     (o_done)
    );

    // Result strobe only arrives once the block is free again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // An accepted command keeps the block busy next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("accepted command did not start a scan");

    // accepted flag agrees with the status code
    a_accept_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.accepted == ((o_result.status == ST_ADMIT)
            || (o_result.status == ST_REL) || (o_result.status == ST_FREED))))
        else $error("accepted flag inconsistent with status");

    // A freed source reports zero open connections
    a_freed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == ST_FREED)) |-> (o_result.source_count == 16'd0))
        else $error("freed entry reports nonzero count");

endmodule
